// ===== rtl/dis_pkg.sv =====
// Shared types, constants and the Adler-32 step function for the image scanner.
`default_nettype none

package dis_pkg;

    localparam int WINDOW_BYTES = 113;
    localparam int HEAD_BYTES   = 12;
    localparam int CHAIN_CELLS  = WINDOW_BYTES - HEAD_BYTES;
    localparam int CHECK_BYTES  = 44;

    localparam logic [30:0] CHECK_START  = 31'(WINDOW_BYTES - 1);
    localparam logic [30:0] WINDOW_LEN   = 31'(WINDOW_BYTES);
    localparam logic [31:0] HDR_SIZE     = 32'h0000_0070;
    localparam logic [31:0] WINDOW_SIZE  = 32'(WINDOW_BYTES);
    localparam logic [31:0] ENDIAN_TAG   = 32'h1234_5678;
    localparam logic [16:0] ADLER_MOD    = 17'd65521;

    localparam logic [7:0] MAGIC_D      = 8'h64;
    localparam logic [7:0] MAGIC_E      = 8'h65;
    localparam logic [7:0] MAGIC_X      = 8'h78;
    localparam logic [7:0] MAGIC_NL     = 8'h0A;
    localparam logic [7:0] DIGIT_LOW    = 8'h30;
    localparam logic [7:0] DIGIT_HIGH   = 8'h39;

    localparam int OFS_CHECKSUM = 8;
    localparam int OFS_FILE_SIZE = 32;
    localparam int OFS_HDR_SIZE = 36;
    localparam int OFS_ENDIAN   = 40;

    typedef struct packed {
        logic [15:0] b;
        logic [15:0] a;
    } adler_t;

    localparam adler_t ADLER_INIT = '{b: 16'd0, a: 16'd1};

    typedef struct packed {
        logic [29:0] image_offset;
        logic [30:0] image_length;
        logic [31:0] computed_checksum;
        logic [31:0] stored_checksum;
        logic        checksum_ok;
    } result_t;

    function automatic adler_t adler_fold(adler_t s, logic [7:0] d);
        logic [16:0] a_sum;
        logic [16:0] b_sum;
        adler_t      r;
        a_sum = {1'b0, s.a} + {9'b0, d};
        r.a   = (a_sum >= ADLER_MOD) ? 16'(a_sum - ADLER_MOD) : a_sum[15:0];
        b_sum = {1'b0, s.b} + {1'b0, r.a};
        r.b   = (b_sum >= ADLER_MOD) ? 16'(b_sum - ADLER_MOD) : b_sum[15:0];
        return r;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= DIGIT_LOW) && (c <= DIGIT_HIGH);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dex_image_scanner_core.sv =====
// Top level of the image scanner: cell chain, header check, image tracking and result staging.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_valid / s_ready    s_data_byte
//   m_       out        m_valid / m_ready    image offset, length, checksums, match flag
//   cfg_     in         cfg_wr_en            cfg_wr_data (region length)
//
// One request is taken every cycle while s_ready is high; each byte shifts the cell chain
// and is folded into every cell's running checksum in the same cycle, so a header check
// completes with its byte. A result is registered in the output or the skid register.
// A second result may wait in a skid register; s_ready drops only while that is full.
// Reset is synchronous and active low; it clears the region length, position, image and output state.
`default_nettype none

module dex_image_scanner_core #(
    parameter int REGION_ADDR_BITS = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [29:0] m_image_offset,
    output logic [30:0] m_image_length,
    output logic [31:0] m_computed_checksum,
    output logic [31:0] m_stored_checksum,
    output logic        m_checksum_ok
);

    localparam logic [32:0] REGION_LIMIT = 33'd1 << REGION_ADDR_BITS;

    logic accept;

    logic [30:0]     region_length_reg;
    logic [30:0]     pos_reg, pos_next;
    logic            in_image_reg, in_image_next;
    logic [30:0]     bytes_left_reg, bytes_left_next;
    dis_pkg::adler_t sum_reg, sum_next;
    logic [31:0]     held_stored_reg, held_stored_next;
    logic [29:0]     held_start_reg, held_start_next;
    logic [30:0]     held_length_reg, held_length_next;

    logic [7:0] head_reg [0:dis_pkg::HEAD_BYTES-1];

    logic [7:0]      cell_byte [0:dis_pkg::CHAIN_CELLS-1];
    dis_pkg::adler_t cell_sum  [0:dis_pkg::CHAIN_CELLS-1];
    dis_pkg::adler_t sum_full;

    logic [7:0] win [0:dis_pkg::CHECK_BYTES-1];

    dis_pkg::result_t res;
    logic             res_valid;

    dis_pkg::result_t out_reg, out_next, skid_reg, skid_next;
    logic             out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    genvar gi;
    generate
        for (gi = 0; gi < dis_pkg::CHAIN_CELLS; gi++) begin : g_cell
            if (gi == dis_pkg::CHAIN_CELLS - 1) begin : g_tail
                dis_cell u_cell (
                    .aclk      (aclk),
                    .advance   (accept),
                    .byte_in   (s_data_byte),
                    .sum_in    (dis_pkg::ADLER_INIT),
                    .data_byte (s_data_byte),
                    .byte_out  (cell_byte[gi]),
                    .sum_out   (cell_sum[gi]),
                    .sum_next  ()
                );
            end else if (gi == 0) begin : g_head
                dis_cell u_cell (
                    .aclk      (aclk),
                    .advance   (accept),
                    .byte_in   (cell_byte[gi+1]),
                    .sum_in    (cell_sum[gi+1]),
                    .data_byte (s_data_byte),
                    .byte_out  (cell_byte[gi]),
                    .sum_out   (cell_sum[gi]),
                    .sum_next  (sum_full)
                );
            end else begin : g_mid
                dis_cell u_cell (
                    .aclk      (aclk),
                    .advance   (accept),
                    .byte_in   (cell_byte[gi+1]),
                    .sum_in    (cell_sum[gi+1]),
                    .data_byte (s_data_byte),
                    .byte_out  (cell_byte[gi]),
                    .sum_out   (cell_sum[gi]),
                    .sum_next  ()
                );
            end
        end

        for (gi = 0; gi < dis_pkg::CHECK_BYTES; gi++) begin : g_win
            if (gi < dis_pkg::HEAD_BYTES - 1) begin : g_h
                assign win[gi] = head_reg[gi+1];
            end else begin : g_c
                assign win[gi] = cell_byte[gi-dis_pkg::HEAD_BYTES+1];
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int k = 0; k < dis_pkg::HEAD_BYTES - 1; k++) begin
                head_reg[k] <= head_reg[k+1];
            end
            head_reg[dis_pkg::HEAD_BYTES-1] <= cell_byte[0];
        end
    end

    logic        restart;
    logic [30:0] pos_eff, bytes_left_eff, start, room;
    logic        in_image_eff;
    logic        region_fits, magic_ok, hit;
    logic [31:0] fsz, hdr_word, endian_word, stored_word;

    always_comb begin
        restart        = pos_reg >= region_length_reg;
        pos_eff        = restart ? 31'd0 : pos_reg;
        bytes_left_eff = restart ? 31'd0 : bytes_left_reg;
        in_image_eff   = restart ? 1'b0 : in_image_reg;
        region_fits    = {2'b00, region_length_reg} <= REGION_LIMIT;
        start          = pos_eff - dis_pkg::CHECK_START;
        room           = region_length_reg - start;

        fsz = {win[dis_pkg::OFS_FILE_SIZE+3], win[dis_pkg::OFS_FILE_SIZE+2],
               win[dis_pkg::OFS_FILE_SIZE+1], win[dis_pkg::OFS_FILE_SIZE]};
        hdr_word = {win[dis_pkg::OFS_HDR_SIZE+3], win[dis_pkg::OFS_HDR_SIZE+2],
                    win[dis_pkg::OFS_HDR_SIZE+1], win[dis_pkg::OFS_HDR_SIZE]};
        endian_word = {win[dis_pkg::OFS_ENDIAN+3], win[dis_pkg::OFS_ENDIAN+2],
                       win[dis_pkg::OFS_ENDIAN+1], win[dis_pkg::OFS_ENDIAN]};
        stored_word = {win[dis_pkg::OFS_CHECKSUM+3], win[dis_pkg::OFS_CHECKSUM+2],
                       win[dis_pkg::OFS_CHECKSUM+1], win[dis_pkg::OFS_CHECKSUM]};

        magic_ok = (win[0] == dis_pkg::MAGIC_D) && (win[1] == dis_pkg::MAGIC_E) &&
                   (win[2] == dis_pkg::MAGIC_X) && (win[3] == dis_pkg::MAGIC_NL) &&
                   dis_pkg::is_digit(win[4]) && dis_pkg::is_digit(win[5]) &&
                   dis_pkg::is_digit(win[6]) && (win[7] == 8'h00);
        hit = magic_ok && (hdr_word == dis_pkg::HDR_SIZE) &&
              (endian_word == dis_pkg::ENDIAN_TAG) &&
              (fsz >= dis_pkg::HDR_SIZE) && (fsz <= {1'b0, room});

        pos_next         = pos_reg;
        in_image_next    = in_image_reg;
        bytes_left_next  = bytes_left_reg;
        sum_next         = sum_reg;
        held_stored_next = held_stored_reg;
        held_start_next  = held_start_reg;
        held_length_next = held_length_reg;
        res_valid        = 1'b0;

        if (accept) begin
            pos_next        = pos_eff + 31'd1;
            in_image_next   = in_image_eff;
            bytes_left_next = bytes_left_eff;
            if (bytes_left_eff != 31'd0) begin
                if (in_image_eff && (bytes_left_eff >= dis_pkg::WINDOW_LEN)) begin
                    sum_next = dis_pkg::adler_fold(sum_reg, s_data_byte);
                    if (bytes_left_eff == dis_pkg::WINDOW_LEN) begin
                        res_valid     = 1'b1;
                        in_image_next = 1'b0;
                    end
                end
                bytes_left_next = bytes_left_eff - 31'd1;
            end else if ((pos_eff >= dis_pkg::CHECK_START) && region_fits && hit) begin
                sum_next         = (fsz >= dis_pkg::WINDOW_SIZE) ? sum_full : cell_sum[1];
                held_stored_next = stored_word;
                held_start_next  = start[29:0];
                held_length_next = fsz[30:0];
                bytes_left_next  = fsz[30:0] - 31'd1;
                if (fsz <= dis_pkg::WINDOW_SIZE) begin
                    res_valid     = 1'b1;
                    in_image_next = 1'b0;
                end else begin
                    in_image_next = 1'b1;
                end
            end
        end

        res.image_offset      = held_start_next;
        res.image_length      = held_length_next;
        res.computed_checksum = {sum_next.b, sum_next.a};
        res.stored_checksum   = held_stored_next;
        res.checksum_ok       = ({sum_next.b, sum_next.a} == held_stored_next);
    end

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = res;
                out_valid_next = res_valid;
            end
        end else if (res_valid) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_length_reg <= '0;
            pos_reg           <= '0;
            in_image_reg      <= 1'b0;
            bytes_left_reg    <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                region_length_reg <= cfg_wr_data;
            end
            pos_reg        <= pos_next;
            in_image_reg   <= in_image_next;
            bytes_left_reg <= bytes_left_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        sum_reg         <= sum_next;
        held_stored_reg <= held_stored_next;
        held_start_reg  <= held_start_next;
        held_length_reg <= held_length_next;
        out_reg         <= out_next;
        skid_reg        <= skid_next;
    end

    assign m_valid             = out_valid_reg;
    assign m_image_offset      = out_reg.image_offset;
    assign m_image_length      = out_reg.image_length;
    assign m_computed_checksum = out_reg.computed_checksum;
    assign m_stored_checksum   = out_reg.stored_checksum;
    assign m_checksum_ok       = out_reg.checksum_ok;

endmodule

`default_nettype wire

// ===== rtl/dis_cell.sv =====
// One window cell: holds a byte and the running Adler-32 from that byte to the newest one.
`default_nettype none

module dis_cell (
    input  logic           aclk,
    input  logic           advance,
    input  logic [7:0]     byte_in,
    input  dis_pkg::adler_t sum_in,
    input  logic [7:0]     data_byte,
    output logic [7:0]     byte_out,
    output dis_pkg::adler_t sum_out,
    output dis_pkg::adler_t sum_next
);

    logic [7:0]      byte_reg;
    dis_pkg::adler_t sum_reg;

    assign sum_next = dis_pkg::adler_fold(sum_in, data_byte);
    assign byte_out = byte_reg;
    assign sum_out  = sum_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            byte_reg <= byte_in;
            sum_reg  <= sum_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dis_checker.sv =====
// Port-level checks for the image scanner, bound to its top level.
`default_nettype none

module dis_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [30:0] m_image_length,
    input logic [31:0] m_computed_checksum,
    input logic [31:0] m_stored_checksum,
    input logic        m_checksum_ok
);

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

    a_stalled_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_computed_checksum) &&
        $stable(m_stored_checksum) && $stable(m_image_length))
        else $error("Stalled result changed or was dropped.");

    a_match_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_checksum_ok == (m_computed_checksum == m_stored_checksum))
        else $error("Match flag disagrees with the checksums.");

    a_result_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_image_length >= 31'd112) &&
        (m_computed_checksum[15:0] < 16'd65521) &&
        (m_computed_checksum[31:16] < 16'd65521))
        else $error("Result length or checksum half out of range.");

endmodule

bind dex_image_scanner_core dis_checker u_dis_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_image_length      (m_image_length),
    .m_computed_checksum (m_computed_checksum),
    .m_stored_checksum   (m_stored_checksum),
    .m_checksum_ok       (m_checksum_ok)
);

`default_nettype wire
